### rtl/core/assert_macros.svh
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/stbs_pkg.sv
package stbs_pkg;

  localparam int OPCODE_W    = 1;
  localparam int INDEX_W     = 10;
  localparam int VALUE_W     = 32;
  localparam int POSITION_W  = 10;
  localparam int CFG_COUNT_W = 11;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  localparam logic [OPCODE_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_SEARCH = 1'b1;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } stbs_state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] value;
  } stbs_req_t;

  typedef struct packed {
    logic                  valid;
    logic                  found;
    logic [POSITION_W-1:0] position;
  } stbs_res_t;

endpackage

### rtl/core/stbs_if.sv
interface stbs_in_if;
  logic                                          valid;
  logic                                          ready;
  logic [stbs_pkg::OPCODE_W-1:0]                 opcode;
  logic [stbs_pkg::INDEX_W-1:0]                  entry_index;
  logic signed [stbs_pkg::VALUE_W-1:0]           value;

  modport source(output valid, opcode, entry_index, value, input ready);
  modport sink(input valid, opcode, entry_index, value, output ready);
endinterface

interface stbs_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [stbs_pkg::POSITION_W-1:0]     position;

  modport source(output valid, found, position, input ready);
  modport sink(input valid, found, position, output ready);
endinterface

### rtl/core/stbs_engine.sv
module stbs_engine #(
  parameter int TABLE_DEPTH = 1024,
  parameter int IDX_W       = 10,
  parameter int CNT_W       = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  stbs_pkg::stbs_req_t req,
  input  logic [CNT_W-1:0]    count,
  output stbs_pkg::stbs_res_t res,
  input  logic                res_ready
);

  stbs_pkg::stbs_state_t state_r, state_nxt;

  logic signed [stbs_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];
  logic signed [stbs_pkg::VALUE_W-1:0] rdata_r;
  logic signed [stbs_pkg::VALUE_W-1:0] key_r;

  logic [CNT_W-1:0] lo_r, hix_r, mid_r;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;

  logic             accept, is_search, hit, below, more;
  logic             rd_en, wr_en;
  logic [CNT_W-1:0] lo_src, hix_src, mid_calc;
  logic [CNT_W:0]   mid_sum;

  assign accept    = req_valid && req_ready;
  assign is_search = (req.opcode == stbs_pkg::OP_SEARCH);
  assign hit       = (rdata_r == key_r);
  assign below     = (rdata_r < key_r);

  // bounds: [lo, hix) with hix exclusive, so no negative right bound
  always_comb begin
    if (state_r == stbs_pkg::ST_IDLE) begin
      lo_src  = '0;
      hix_src = count;
    end else begin
      lo_src  = below ? CNT_W'(mid_r + CNT_W'(1)) : lo_r;
      hix_src = below ? hix_r : mid_r;
    end
  end

  assign more     = (lo_src < hix_src);
  assign mid_sum  = (CNT_W+1)'(lo_src) + (CNT_W+1)'(hix_src) - (CNT_W+1)'(1);
  assign mid_calc = mid_sum[CNT_W:1];

  assign rd_en = ((state_r == stbs_pkg::ST_IDLE) && accept && is_search && more) ||
                 ((state_r == stbs_pkg::ST_SEARCH) && !hit && more);
  assign wr_en = (state_r == stbs_pkg::ST_IDLE) && accept && !is_search &&
                 (32'(req.entry_index) < 32'(TABLE_DEPTH));

  assign found_nxt = (state_r == stbs_pkg::ST_SEARCH) && hit;
  assign pos_nxt   = found_nxt ? mid_r : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (accept && is_search) begin
          state_nxt = more ? stbs_pkg::ST_SEARCH : stbs_pkg::ST_DONE;
        end
      end
      stbs_pkg::ST_SEARCH: begin
        if (hit || !more) begin
          state_nxt = stbs_pkg::ST_DONE;
        end
      end
      stbs_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = stbs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stbs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready    = 1'b0;
    res.valid    = 1'b0;
    res.found    = found_r;
    res.position = stbs_pkg::POSITION_W'(pos_r);
    case (state_r)
      stbs_pkg::ST_IDLE:   req_ready = 1'b1;
      stbs_pkg::ST_SEARCH: req_ready = 1'b0;
      stbs_pkg::ST_DONE:   res.valid = 1'b1;
      default:             req_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= req.value;
    end
    if (rd_en) begin
      lo_r  <= lo_src;
      hix_r <= hix_src;
      mid_r <= mid_calc;
    end
    if (state_r != stbs_pkg::ST_DONE) begin
      found_r <= found_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // single-port table: writes only while idle, so no read/write overlap
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(req.entry_index)] <= req.value;
    end else if (rd_en) begin
      rdata_r <= mem[IDX_W'(mid_calc)];
    end
  end

endmodule

### rtl/core/sorted_table_binary_search_top.sv
// Binary search over a sorted table of signed 32-bit entries held in one
// single-port synchronous RAM of TABLE_DEPTH words. A write item (opcode 0)
// stores value at entry_index and returns nothing; an index at or
// beyond TABLE_DEPTH is dropped. A search item (opcode 1) probes
// mid = (left+right)/2 over entries 0..entry_count-1 and returns one result:
// found, and the position of the matching probe (0 when not found). The table
// is never cleared; software writes every entry below entry_count before
// searching. A search holds the input side from acceptance until the done
// state hands the result to the output register. It makes p probes (at most
// floor(log2(entry_count))+1, so 11 at 1024 entries); each probe is one RAM
// read whose registered data picks the next address, and the first read, if
// any, is issued when the search is accepted. The output register lets the
// next item start while a result waits for transfer. entry_count is at APB
// byte address 0; a write keeps pwdata[10:0] and saturates above TABLE_DEPTH,
// and reads return the stored value.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  stbs_in_if.sink                             in_item,
  stbs_out_if.source                          out_result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stbs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [stbs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [stbs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  // wide enough to hold TABLE_DEPTH itself
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // ---- configuration register ----
  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic [stbs_pkg::CFG_COUNT_W-1:0]    wr_count;
  logic                                cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[3:2] == stbs_pkg::REG_ENTRY_COUNT);
  assign wr_count = pwdata[stbs_pkg::CFG_COUNT_W-1:0];
  // clamp to the table size
  assign count_nxt = (32'(wr_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(wr_count);

  always_comb begin
    prdata = '0;
    if (paddr[3:2] == stbs_pkg::REG_ENTRY_COUNT) begin
      prdata = stbs_pkg::APB_DATA_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr) begin
      count_r <= count_nxt;
    end
  end

  // ---- search engine with the table RAM ----
  stbs_pkg::stbs_req_t req;
  stbs_pkg::stbs_res_t res;
  logic                res_ready;

  assign req.opcode      = in_item.opcode;
  assign req.entry_index = in_item.entry_index;
  assign req.value       = in_item.value;

  stbs_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_item.valid),
    .req_ready (in_item.ready),
    .req       (req),
    .count     (count_r),
    .res       (res),
    .res_ready (res_ready)
  );

  // ---- output register ----
  // Loads when empty or when the held result transfers this cycle.
  logic                              out_valid_r;
  logic                              out_found_r;
  logic [stbs_pkg::POSITION_W-1:0]   out_position_r;
  logic                              load;

  assign res_ready = !out_valid_r || out_result.ready;
  assign load      = res.valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_result.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_found_r    <= res.found;
      out_position_r <= res.position;
    end
  end

  assign out_result.valid    = out_valid_r;
  assign out_result.found    = out_found_r;
  assign out_result.position = out_position_r;

endmodule

### rtl/core/stbs_checker.sv
`include "assert_macros.svh"

module stbs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [stbs_pkg::OPCODE_W-1:0]       in_opcode,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_found,
  input logic [stbs_pkg::POSITION_W-1:0]     out_position,
  input logic                                pready
);

  `ASSERT_CLK(a_miss_pos_zero, clk, rst_n, out_valid && !out_found |-> out_position == '0, "position not zero on a miss")
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_position), "result changed while stalled")
  `ASSERT_CLK(a_search_busy, clk, rst_n, in_valid && in_ready && (in_opcode == stbs_pkg::OP_SEARCH) |=> !in_ready, "input ready right after a search transfer")
  `ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_item.valid),
  .in_ready     (in_item.ready),
  .in_opcode    (in_item.opcode),
  .out_valid    (out_result.valid),
  .out_ready    (out_result.ready),
  .out_found    (out_result.found),
  .out_position (out_result.position),
  .pready       (pready)
);

### sim/sorted_table_binary_search_top_tb.sv
// Testbench for the sorted-table binary search block.
// A shadow copy of the table and of entry_count predicts every search result.
// The checker compares each result transfer against the oldest prediction.
module sorted_table_binary_search_top_tb;

  localparam int TABLE_DEPTH   = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RX_HOLD_CYCLES = 300;     // long output stall
  localparam int PHASE_ITEMS   = 180;      // random items per idling phase

  // register indexes with no register behind them
  localparam logic [1:0] REG_SPARE_LO = 2'd1;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  typedef struct {
    logic                            found;
    logic [stbs_pkg::POSITION_W-1:0] position;
  } search_result_t;

  logic clk;
  logic rst_n;

  // APB side
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [stbs_pkg::APB_ADDR_W-1:0] paddr;
  logic [stbs_pkg::APB_DATA_W-1:0] pwdata;
  logic [stbs_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  stbs_in_if  in_ch ();
  stbs_out_if out_ch ();

  sorted_table_binary_search_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_result(out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow state of the block: table contents and the search bound.
  logic signed [stbs_pkg::VALUE_W-1:0] shadow_entries [TABLE_DEPTH];
  int                                  shadow_count;

  search_result_t pending_results [$];   // predicted results, oldest first
  int             mismatch_count;
  int             items_accepted;
  int             cycle_count;

  // Idling controls, in percent of cycles.
  int tx_idle_pct;
  int rx_idle_pct;
  // Long receiver hold-off: main flow raises the request, receiver counts.
  logic rx_hold_request;
  int   rx_hold_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Binary search over the shadow table, probes exactly as the block does.
  // A match ends the search at the first matching probe, even when the
  // table is not sorted.
  function automatic search_result_t lookup_key(logic signed [stbs_pkg::VALUE_W-1:0] key);
    search_result_t r;
    int lo;
    int hi;
    int mid;
    r.found    = 1'b0;
    r.position = '0;
    lo = 0;
    hi = shadow_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_entries[mid] == key) begin
        r.found    = 1'b1;
        r.position = mid[stbs_pkg::POSITION_W-1:0];
        return r;
      end
      if (shadow_entries[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return r;
  endfunction

  // Called at the edge where an input transfer happens.
  function automatic void apply_item(stbs_pkg::stbs_req_t req);
    if (req.opcode == stbs_pkg::OP_WRITE) begin
      // the index field cannot reach past a 1024-deep table
      shadow_entries[req.entry_index] = req.value;
    end else begin
      pending_results.push_back(lookup_key(req.value));
    end
  endfunction

  // Count is masked to its 11 bits, then saturated to the table depth.
  // Writes to any other register index are dropped.
  function automatic void apply_config(logic [stbs_pkg::APB_ADDR_W-1:0] addr,
                                       logic [stbs_pkg::APB_DATA_W-1:0] data);
    int c;
    if (addr[3:2] == stbs_pkg::REG_ENTRY_COUNT) begin
      c = int'(data[stbs_pkg::CFG_COUNT_W-1:0]);
      if (c > TABLE_DEPTH) c = TABLE_DEPTH;
      shadow_count = c;
    end
  endfunction

  function automatic logic [stbs_pkg::APB_ADDR_W-1:0] reg_addr(logic [1:0] index);
    return {index, 2'b00};
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: every output transfer pops one prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    search_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no search pending: found %0d position %0d",
               out_ch.found, out_ch.position);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_ch.found);
          mismatch_count++;
        end
        if (out_ch.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_ch.position);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random ready, or a long counted hold-off on request.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ch.ready = 1'b0;
      rx_hold_left--;
    end else if (rx_hold_request) begin
      rx_hold_request = 1'b0;
      rx_hold_left    = RX_HOLD_CYCLES - 1;
      out_ch.ready    = 1'b0;
    end else begin
      out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Drop input valid at the next falling edge.
  task automatic input_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Offer one item, with random gaps first; returns at the transfer edge
  // with valid still high so a following item can go back to back.
  task automatic send_item(input stbs_pkg::stbs_req_t req);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid       = 1'b0;
      in_ch.opcode      = $urandom_range(1) ? stbs_pkg::OP_SEARCH : stbs_pkg::OP_WRITE;
      in_ch.entry_index = stbs_pkg::INDEX_W'($urandom());
      in_ch.value       = $urandom();
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.opcode      = req.opcode;
    in_ch.entry_index = req.entry_index;
    in_ch.value       = req.value;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(req);
    items_accepted++;
  endtask

  task automatic send_write(input int index,
                            input logic signed [stbs_pkg::VALUE_W-1:0] data);
    stbs_pkg::stbs_req_t req;
    req.opcode      = stbs_pkg::OP_WRITE;
    req.entry_index = index[stbs_pkg::INDEX_W-1:0];
    req.value       = data;
    send_item(req);
  endtask

  task automatic send_search(input logic signed [stbs_pkg::VALUE_W-1:0] key);
    stbs_pkg::stbs_req_t req;
    req.opcode      = stbs_pkg::OP_SEARCH;
    req.entry_index = stbs_pkg::INDEX_W'($urandom());   // ignored by a search
    req.value       = key;
    send_item(req);
  endtask

  // Wait until every predicted result has come out, then let a trailing
  // write (which gives no result) finish inside the block.
  task automatic wait_results_drained();
    input_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, access, register lands at the access edge.
  task automatic cfg_write(input logic [stbs_pkg::APB_ADDR_W-1:0] addr,
                           input logic [stbs_pkg::APB_DATA_W-1:0] data);
    input_idle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    apply_config(addr, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // APB read of entry_count, compared with the shadow value.
  task automatic check_entry_count();
    logic [stbs_pkg::APB_DATA_W-1:0] got;
    input_idle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = reg_addr(stbs_pkg::REG_ENTRY_COUNT);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== stbs_pkg::APB_DATA_W'(shadow_count)) begin
      $error("entry_count: expected %0d, actual %0d", shadow_count, got);
      mismatch_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_entry_count(input int count);
    wait_results_drained();
    cfg_write(reg_addr(stbs_pkg::REG_ENTRY_COUNT), stbs_pkg::APB_DATA_W'(count));
    check_entry_count();
  endtask

  // Key picker: mostly keys in the searched range, some neighbors of them,
  // some anything at all.
  function automatic logic signed [stbs_pkg::VALUE_W-1:0] pick_key();
    int r;
    logic signed [stbs_pkg::VALUE_W-1:0] k;
    r = $urandom_range(99);
    if (shadow_count > 0 && r < 60) begin
      k = shadow_entries[$urandom_range(shadow_count - 1)];
    end else if (shadow_count > 0 && r < 78) begin
      k = shadow_entries[$urandom_range(shadow_count - 1)];
      k = $urandom_range(1) ? k + 1 : k - 1;
    end else if (r < 84) begin
      k = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      k = $urandom();
    end
    return k;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Count of zero: no probes, never found. Table is still unwritten here.
  task automatic test_empty_table();
    check_entry_count();
    set_entry_count(0);
    send_search(32'sd0);
    send_search(32'sh8000_0000);
    send_search(32'sh7fff_ffff);
  endtask

  // Eight sorted entries spanning the full signed range, with a duplicate.
  task automatic test_extreme_entries();
    logic signed [stbs_pkg::VALUE_W-1:0] vals [8];
    vals = '{32'sh8000_0000, 32'sh8000_0001, -32'sd1, 32'sd0,
             32'sd0, 32'sd1, 32'sh7fff_fffe, 32'sh7fff_ffff};
    foreach (vals[i]) send_write(i, vals[i]);
    set_entry_count(8);
    foreach (vals[i]) if (i != 4) send_search(vals[i]);
    send_search(32'sd5);       // between entries
    send_search(-32'sd5);
    // single entry searched
    set_entry_count(1);
    send_search(32'sh8000_0000);
  endtask

  // Whole table written in order, then the deepest searches, including a
  // count written above the table depth (saturates).
  task automatic test_full_table();
    int vals [$];
    for (int i = 0; i < TABLE_DEPTH; i++) vals.push_back(int'($urandom()));
    vals.sort();
    foreach (vals[i]) send_write(i, vals[i]);
    set_entry_count(2047);
    repeat (30) send_search(pick_key());
    set_entry_count(TABLE_DEPTH - 1);
    repeat (10) send_search(pick_key());
    set_entry_count(TABLE_DEPTH);
    repeat (10) send_search(pick_key());
  endtask

  // Writes to unused register indexes must leave entry_count alone.
  task automatic test_unknown_register();
    wait_results_drained();
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
      cfg_write(reg_addr(i[1:0]), $urandom());
      check_entry_count();
    end
  endtask

  // Receiver stops for a long time while searches keep coming, so the
  // block fills and stalls its input; then the sender waits for drain.
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_entry_count(TABLE_DEPTH);
    @(posedge clk);
    rx_hold_request = 1'b1;
    repeat (12) send_search(pick_key());
    wait_results_drained();
  endtask

  // One round: fill a short sorted prefix, pick a count, search it, with
  // stray writes that may break the ordering.
  task automatic run_search_round();
    int vals [$];
    int n;
    int count;
    int r;
    bit narrow;
    n      = ($urandom_range(99) < 95) ? $urandom_range(1, 40) : $urandom_range(41, 300);
    narrow = $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(4) == 0) vals.push_back(vals[i-1]);
      else if (narrow) vals.push_back(int'($urandom_range(63)) - 32);
      else vals.push_back(int'($urandom()));
    end
    vals.sort();
    foreach (vals[i]) send_write(i, vals[i]);

    // whole table is written by now, so any count is legal
    r = $urandom_range(99);
    if (r < 75) count = n;
    else if (r < 92) count = $urandom_range(n);
    else if (r < 96) count = TABLE_DEPTH;
    else count = 2047;
    set_entry_count(count);

    repeat ($urandom_range(4, 14)) begin
      r = $urandom_range(99);
      if (r < 8 && shadow_count > 0) begin
        send_write($urandom_range(shadow_count - 1), $urandom());   // unsorts
      end else if (r < 12) begin
        send_write($urandom_range(TABLE_DEPTH - 1), $urandom());
      end else begin
        send_search(pick_key());
      end
    end
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    int stop_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at     = items_accepted + PHASE_ITEMS;
    while (items_accepted < stop_at) run_search_round();
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = stbs_pkg::OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.value       = '0;
    out_ch.ready      = 1'b0;
    rx_hold_request   = 1'b0;
    rx_hold_left      = 0;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    mismatch_count    = 0;
    items_accepted    = 0;
    cycle_count       = 0;
    shadow_count      = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, sender idles 30 percent, receiver 85
    tx_idle_pct = 30;
    rx_idle_pct = 85;
    test_empty_table();
    test_extreme_entries();
    test_unknown_register();

    // random part
    tx_idle_pct = 30;
    rx_idle_pct = 85;
    test_full_table();
    test_random_traffic(30, 85);
    test_random_traffic(85, 30);
    test_output_stall();
    test_random_traffic(0, 0);

    wait_results_drained();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
